>>> rtl/msk_pkg.sv
// Package for the multi-stack engine: field widths, operation and status codes,
// default sizes, and the command/status structs between controller and datapath.
// No dependencies.
package msk_pkg;

   localparam int DEF_NUM_STACKS = 1024;
   localparam int DEF_POOL_DEPTH = 4096;

   localparam int KIND_W     = 2;
   localparam int SIDX_W     = 10;
   localparam int VALUE_W    = 32;
   localparam int CFG_W      = 11;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   localparam logic STATUS_TOP  = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clr_wr;       // clear one stack entry after reset
      logic take;         // capture request, read stack entry and free-list link
      logic push_commit;  // link a new node on top of the stack
      logic emit_full;    // report a dropped push
      logic node_rd;      // read value and link of the top node
      logic emit_top;     // report the top value
      logic pop_commit;   // unlink the top node and recycle it
   } msk_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic              clr_last;
      logic              req_ok;
      logic [KIND_W-1:0] kind;
      logic              nonempty;
      logic              pool_free;
      logic              out_free;
   } msk_stat_type;

endpackage

>>> rtl/msk_ctrl.sv
// Controller of the multi-stack engine: sequences the clearing pass and the
// steps of each request. Depends on msk_pkg.
module msk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output msk_pkg::msk_cmd_type  cmd,
   input  msk_pkg::msk_stat_type stat
);
   import msk_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HEAD,
      ST_NODE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            // Requests with an unused kind or a stack out of range are dropped here.
            if (req_tvalid && stat.req_ok) begin
               cmd.take = 1'b1;
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            if (stat.kind == KIND_PUSH) begin
               if (stat.pool_free) begin
                  cmd.push_commit = 1'b1;
                  state_in        = ST_IDLE;
               end else if (stat.out_free) begin
                  cmd.emit_full = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else if (stat.nonempty) begin
               cmd.node_rd = 1'b1;
               state_in    = ST_NODE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NODE: begin
            if (stat.kind == KIND_READ) begin
               if (stat.out_free) begin
                  cmd.emit_top = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.pop_commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/msk_datapath.sv
// Datapath of the multi-stack engine: stack head memory, node pool memories,
// free-list registers, configuration register and result register.
// Depends on msk_pkg.
module msk_datapath #(
   parameter int NUM_STACKS = msk_pkg::DEF_NUM_STACKS,
   parameter int POOL_DEPTH = msk_pkg::DEF_POOL_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [msk_pkg::CFG_W-1:0]      csr_wr_data,
   input  logic [msk_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [msk_pkg::KIND_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [msk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tuser,
   input  msk_pkg::msk_cmd_type           cmd,
   output msk_pkg::msk_stat_type          stat
);
   import msk_pkg::*;

   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int AW = $clog2(POOL_DEPTH);
   localparam int NW = AW + 1;
   localparam logic [NW-1:0] NULL_MARK = NW'(POOL_DEPTH);

   // Stack entry: nonempty flag on top, head node below it.
   logic [AW:0]         stack_mem [NUM_STACKS];
   logic [VALUE_W-1:0]  value_mem [POOL_DEPTH];
   logic [NW-1:0]       link_mem  [POOL_DEPTH];

   logic [CFG_W-1:0]    cfg_ff;
   logic [SW-1:0]       clr_idx_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [SW-1:0]       sidx_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [AW:0]         st_rd_ff;
   logic [VALUE_W-1:0]  val_rd_ff;
   logic [NW-1:0]       link_rd_ff;
   logic [NW-1:0]       recyc_ff;
   logic [NW-1:0]       bump_ff;
   logic                rsp_valid_ff;
   logic                rsp_status_ff;
   logic [VALUE_W-1:0]  rsp_top_ff;

   logic [SIDX_W-1:0]   req_idx;
   logic [31:0]         req_idx_wide;
   logic [SW-1:0]       req_addr;
   logic                recyc_avail;
   logic [AW-1:0]       head;
   logic [AW-1:0]       new_node;
   logic                st_we;
   logic [SW-1:0]       st_wa;
   logic [AW:0]         st_wd;
   logic                link_we;
   logic [AW-1:0]       link_wa;
   logic [NW-1:0]       link_wd;
   logic [AW-1:0]       link_ra;

   assign req_idx      = req_tdata[SIDX_W-1:0];
   assign req_idx_wide = 32'(req_idx);
   assign req_addr     = req_idx_wide[SW-1:0];
   assign recyc_avail  = recyc_ff < NULL_MARK;
   assign head         = st_rd_ff[AW-1:0];
   assign new_node     = recyc_avail ? recyc_ff[AW-1:0] : bump_ff[AW-1:0];

   assign stat.clr_last  = clr_idx_ff == SW'(NUM_STACKS - 1);
   assign stat.req_ok    = (req_tuser != KIND_UNUSED) && ({1'b0, req_idx} < cfg_ff)
                           && (req_idx_wide < NUM_STACKS);
   assign stat.kind      = kind_ff;
   assign stat.nonempty  = st_rd_ff[AW];
   assign stat.pool_free = recyc_avail || (bump_ff < NULL_MARK);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   // Stack memory write port: clearing pass, push and pop share it.
   always_comb begin
      st_we = cmd.clr_wr || cmd.push_commit || cmd.pop_commit;
      st_wa = cmd.clr_wr ? clr_idx_ff : sidx_ff;
      st_wd = '0;
      if (cmd.push_commit) begin
         st_wd = {1'b1, new_node};
      end else if (cmd.pop_commit) begin
         if (link_rd_ff >= NULL_MARK) begin
            st_wd = {1'b0, head};
         end else begin
            st_wd = {1'b1, link_rd_ff[AW-1:0]};
         end
      end
   end

   // Link memory: a push links the new node to the old top, a pop links the
   // freed node onto the recycled list.
   always_comb begin
      link_we = cmd.push_commit || cmd.pop_commit;
      link_wa = cmd.push_commit ? new_node : head;
      if (cmd.push_commit) begin
         link_wd = st_rd_ff[AW] ? {{(NW-AW){1'b0}}, head} : NULL_MARK;
      end else begin
         link_wd = recyc_ff;
      end
      link_ra = cmd.take ? recyc_ff[AW-1:0] : head;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_mem[st_wa] <= st_wd;
      end
      if (cmd.take) begin
         st_rd_ff <= stack_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_commit) begin
         value_mem[new_node] <= val_ff;
      end
      if (cmd.node_rd) begin
         val_rd_ff <= value_mem[head];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (cmd.take || cmd.node_rd) begin
         link_rd_ff <= link_mem[link_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff <= req_tuser;
         sidx_ff <= req_addr;
         val_ff  <= req_tdata[SIDX_W+VALUE_W-1:SIDX_W];
      end
      if (cmd.emit_top) begin
         rsp_status_ff <= STATUS_TOP;
         rsp_top_ff    <= val_rd_ff;
      end else if (cmd.emit_full) begin
         rsp_status_ff <= STATUS_FULL;
         rsp_top_ff    <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         clr_idx_ff   <= '0;
         recyc_ff     <= NULL_MARK;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (cmd.clr_wr) begin
            clr_idx_ff <= SW'(clr_idx_ff + 1'b1);
         end
         if (cmd.push_commit) begin
            if (recyc_avail) begin
               recyc_ff <= link_rd_ff;
            end else begin
               bump_ff <= NW'(bump_ff + 1'b1);
            end
         end else if (cmd.pop_commit) begin
            recyc_ff <= {{(NW-AW){1'b0}}, head};
         end
         if (cmd.emit_top || cmd.emit_full) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_top_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

>>> rtl/multi_stack_engine.sv
// Top level of the multi-stack engine: linked stacks in a shared node pool.
// Instantiates msk_ctrl and msk_datapath; depends on msk_pkg.
//
//   Port group  Direction  Contents
//   req_*       in         tuser: kind; tdata: stack_index, push_value
//   rsp_*       out        tuser: status; tdata: top_value
//   csr_*       in         write of stacks_in_use
//
// A push, or a read or pop of an empty stack, runs the idle and head states;
// a read or pop of a nonempty stack adds the node state; an ignored request
// uses only the idle state. The two dependent reads (stack head memory, then node memory) set this.
// After reset a clearing pass empties every stack; requests are held off
// meanwhile, csr writes are taken.
// A finished result sits in an output register; a new request is accepted
// while it waits, and only a step that produces a result stalls for it.
module multi_stack_engine #(
   parameter int NUM_STACKS = msk_pkg::DEF_NUM_STACKS,
   parameter int POOL_DEPTH = msk_pkg::DEF_POOL_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [msk_pkg::CFG_W-1:0]      csr_wr_data,   // stacks_in_use
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [msk_pkg::REQ_DATA_W-1:0] req_tdata,     // stack_index, push_value
   input  logic [msk_pkg::KIND_W-1:0]     req_tuser,     // kind
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [msk_pkg::RSP_DATA_W-1:0] rsp_tdata,     // top_value
   output logic                           rsp_tuser      // status
);
   import msk_pkg::*;

   msk_cmd_type  cmd;
   msk_stat_type stat;

   msk_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   msk_datapath #(
      .NUM_STACKS (NUM_STACKS),
      .POOL_DEPTH (POOL_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .stat        (stat)
   );

endmodule

>>> rtl/msk_checker.sv
// Port-level checks for the multi-stack engine, bound to the top level.
// Depends on msk_pkg and multi_stack_engine.
module msk_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [msk_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);
   import msk_pkg::*;

   // A stalled result holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // A dropped push always reports a zero value.
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_FULL) |-> rsp_tdata == '0)
      else $error("pool-full result with nonzero value");

   // The clearing pass keeps requests out right after reset.
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request accepted during clearing pass");

   // A new result is produced only in a step where no request is taken.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("result appeared without a working step");

endmodule

bind multi_stack_engine msk_checker u_msk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
